// ----- design/adcmon_pkg.sv -----
// ---------------------------------------------------------------------------
// ADC monitor package
// Shared widths, command and result codes, controller states and the
// command and status groups between controller and datapath.
// ---------------------------------------------------------------------------
package adcmon_pkg;

    localparam int FIELD_BITS = 16;
    localparam int TOTAL_BITS = 17;
    localparam int CMD_BITS   = 2;
    localparam int KIND_BITS  = 2;

    // input command codes
    localparam logic [CMD_BITS-1:0] CMD_SAMPLE = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_REPORT = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_SCAN   = 2'd2;

    // result kinds
    localparam logic [KIND_BITS-1:0] KIND_REPORT = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_RUN    = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_DONE   = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN_START,
        ST_SKIP,
        ST_RUN
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic clear;          // write zero at clear counter, advance it
        logic sample;         // record the incoming sample
        logic report;         // load a stuck-bit report
        logic scan_begin;     // read map at scan position, load pointer
        logic step;           // advance pointer, read next code
        logic first_set;      // current code opens a missing run
        logic count;          // current code is missing
        logic emit_run_prev;  // run ends just before the current code
        logic emit_run_top;   // run ends at the top code
        logic emit_done;      // walk finished, give the total
    } t_dp_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic clear_last;     // clear counter at the top code
        logic pos_end;        // scan position is past the top code
        logic ptr_top;        // pointer at the top code
        logic seen;           // map bit of the pointer's code
        logic out_busy;       // output holds a transaction not taken now
    } t_dp_status;

endpackage

// ----- design/adcmon_if.sv -----
// ---------------------------------------------------------------------------
// ADC monitor channels
// Valid/ready channels for commands in and results out.
// ---------------------------------------------------------------------------
interface adcmon_in_if import adcmon_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CMD_BITS-1:0]   cmd;
    logic [FIELD_BITS-1:0] sample;

    modport source (output valid, output cmd, output sample, input ready);
    modport sink   (input valid, input cmd, input sample, output ready);
endinterface

interface adcmon_out_if import adcmon_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [KIND_BITS-1:0]  kind;
    logic [FIELD_BITS-1:0] stuck_on;
    logic [FIELD_BITS-1:0] stuck_off;
    logic [FIELD_BITS-1:0] run_first;
    logic [FIELD_BITS-1:0] run_last;
    logic [TOTAL_BITS-1:0] missing_total;

    modport source (output valid, output kind, output stuck_on, output stuck_off,
                    output run_first, output run_last, output missing_total,
                    input ready);
    modport sink   (input valid, input kind, input stuck_on, input stuck_off,
                    input run_first, input run_last, input missing_total,
                    output ready);
endinterface

// ----- design/adc_stuck_bit_and_missing_code_monitor_unit.sv -----
// ---------------------------------------------------------------------------
// ADC stuck-bit and missing-code monitor
// Commands come in on i_in (cmd, sample); results leave on o_out.
// cmd sample: records the code (first one becomes the reference), ORs its
//   difference from the reference into the changed mask, marks the code in
//   the seen map and restarts the walk. It gives no result.
// cmd report: result kind 0 with stuck-on and stuck-off bits, registered
//   and shown the cycle after acceptance.
// cmd scan: walks the seen map from the last stop, one code per cycle
//   through the map RAM's read port; gives the next missing run (kind 1)
//   or, when none is left, the missing total (kind 2). A scan after a run
//   that ended at the top code gives its total without reading the map.
// One command is in work at a time. A new command is taken only while the
// output register is empty or being drained, so a stalled receiver holds
// the input off. After reset a clearing pass zeroes every entry of the seen
// map, during which i_in.ready stays low.
// ---------------------------------------------------------------------------
module adc_stuck_bit_and_missing_code_monitor_unit import adcmon_pkg::*; #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    adcmon_in_if.sink    i_in,
    adcmon_out_if.source o_out
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    adcmon_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_cmd   (i_in.cmd),
        .o_in_ready (i_in.ready),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    adcmon_dp #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .i_sample        (i_in.sample),
        .i_out_ready     (o_out.ready),
        .o_status        (dp_status),
        .o_out_valid     (o_out.valid),
        .o_kind          (o_out.kind),
        .o_stuck_on      (o_out.stuck_on),
        .o_stuck_off     (o_out.stuck_off),
        .o_run_first     (o_out.run_first),
        .o_run_last      (o_out.run_last),
        .o_missing_total (o_out.missing_total)
    );

endmodule

// ----- design/adcmon_ram.sv -----
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module adcmon_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/adcmon_ctrl.sv -----
// ---------------------------------------------------------------------------
// ADC monitor controller
// Sequences the clearing pass, command acceptance and the map walk.
// ---------------------------------------------------------------------------
module adcmon_ctrl import adcmon_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic [CMD_BITS-1:0] i_in_cmd,
    output logic                o_in_ready,
    input  t_dp_status          i_status,
    output t_dp_cmd             o_cmd
);

    t_state r_state;
    t_state n_state;

    // hold the state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_status.clear_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready = !i_status.out_busy;
                if (i_in_valid && !i_status.out_busy) begin
                    case (i_in_cmd)
                        CMD_SAMPLE: o_cmd.sample = 1'b1;
                        CMD_REPORT: o_cmd.report = 1'b1;
                        CMD_SCAN:   n_state = ST_SCAN_START;
                        default:    ;
                    endcase
                end
            end
            ST_SCAN_START: begin
                if (i_status.pos_end) begin
                    o_cmd.emit_done = 1'b1;
                    n_state         = ST_IDLE;
                end else begin
                    o_cmd.scan_begin = 1'b1;
                    n_state          = ST_SKIP;
                end
            end
            ST_SKIP: begin
                if (i_status.seen) begin
                    if (i_status.ptr_top) begin
                        o_cmd.emit_done = 1'b1;
                        n_state         = ST_IDLE;
                    end else begin
                        o_cmd.step = 1'b1;
                    end
                end else begin
                    o_cmd.first_set = 1'b1;
                    o_cmd.count     = 1'b1;
                    if (i_status.ptr_top) begin
                        o_cmd.emit_run_top = 1'b1;
                        n_state            = ST_IDLE;
                    end else begin
                        o_cmd.step = 1'b1;
                        n_state    = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                if (!i_status.seen) begin
                    o_cmd.count = 1'b1;
                    if (i_status.ptr_top) begin
                        o_cmd.emit_run_top = 1'b1;
                        n_state            = ST_IDLE;
                    end else begin
                        o_cmd.step = 1'b1;
                    end
                end else begin
                    o_cmd.emit_run_prev = 1'b1;
                    n_state             = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

endmodule

// ----- design/adcmon_dp.sv -----
// ---------------------------------------------------------------------------
// ADC monitor datapath
// Reference, changed-bits mask, seen map, walk pointer and result register.
// ---------------------------------------------------------------------------
module adcmon_dp import adcmon_pkg::*; #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    input  logic [FIELD_BITS-1:0] i_sample,
    input  logic                  i_out_ready,
    output t_dp_status            o_status,
    output logic                  o_out_valid,
    output logic [KIND_BITS-1:0]  o_kind,
    output logic [FIELD_BITS-1:0] o_stuck_on,
    output logic [FIELD_BITS-1:0] o_stuck_off,
    output logic [FIELD_BITS-1:0] o_run_first,
    output logic [FIELD_BITS-1:0] o_run_last,
    output logic [TOTAL_BITS-1:0] o_missing_total
);

    localparam int ADDR_BITS = SAMPLE_BITS;
    localparam int CNT_BITS  = SAMPLE_BITS + 1;
    localparam logic [CNT_BITS-1:0] CODE_COUNT = {1'b1, {ADDR_BITS{1'b0}}};

    logic [ADDR_BITS-1:0] r_ref;
    logic                 r_taken;
    logic [ADDR_BITS-1:0] r_changed;
    logic [CNT_BITS-1:0]  r_pos;
    logic [CNT_BITS-1:0]  r_missing;
    logic [ADDR_BITS-1:0] r_ptr;
    logic [ADDR_BITS-1:0] r_first;
    logic [ADDR_BITS-1:0] r_clr_cnt;

    logic                  r_out_valid;
    logic [KIND_BITS-1:0]  r_kind;
    logic [FIELD_BITS-1:0] r_stuck_on;
    logic [FIELD_BITS-1:0] r_stuck_off;
    logic [FIELD_BITS-1:0] r_run_first;
    logic [FIELD_BITS-1:0] r_run_last;
    logic [TOTAL_BITS-1:0] r_total;

    logic [ADDR_BITS-1:0] sample_code;
    logic [ADDR_BITS-1:0] ref_eff;
    logic [ADDR_BITS-1:0] still;
    logic [ADDR_BITS-1:0] run_first_val;
    logic [ADDR_BITS-1:0] run_last_val;
    logic                 emit;

    logic                 ram_we;
    logic [ADDR_BITS-1:0] ram_waddr;
    logic [ADDR_BITS-1:0] ram_raddr;
    logic                 ram_rdata;

    assign sample_code   = i_sample[ADDR_BITS-1:0];
    assign ref_eff       = r_taken ? r_ref : sample_code;
    assign still         = ~r_changed;
    assign run_first_val = i_cmd.first_set ? r_ptr : r_first;
    assign run_last_val  = i_cmd.emit_run_prev ? (r_ptr - 1'b1) : r_ptr;
    assign emit          = i_cmd.report | i_cmd.emit_run_prev | i_cmd.emit_run_top
                         | i_cmd.emit_done;

    // map ports: clear or mark on write, walk on read
    assign ram_we    = i_cmd.clear | i_cmd.sample;
    assign ram_waddr = i_cmd.clear ? r_clr_cnt : sample_code;
    assign ram_raddr = i_cmd.step ? (r_ptr + 1'b1) : r_pos[ADDR_BITS-1:0];

    adcmon_ram #(
        .WIDTH (1),
        .DEPTH (1 << ADDR_BITS)
    ) u_seen_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_cmd.sample),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // reference, mask, walk position and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref     <= '0;
            r_taken   <= 1'b0;
            r_changed <= '0;
            r_pos     <= '0;
            r_missing <= '0;
            r_clr_cnt <= '0;
        end else begin
            if (i_cmd.clear) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end
            if (i_cmd.sample) begin
                r_ref     <= ref_eff;
                r_taken   <= 1'b1;
                r_changed <= r_changed | (ref_eff ^ sample_code);
            end
            if (i_cmd.sample || i_cmd.emit_done) begin
                r_pos     <= '0;
                r_missing <= '0;
            end else begin
                if (i_cmd.count) begin
                    r_missing <= r_missing + 1'b1;
                end
                if (i_cmd.emit_run_prev) begin
                    r_pos <= {1'b0, r_ptr};
                end else if (i_cmd.emit_run_top) begin
                    r_pos <= CODE_COUNT;
                end
            end
        end
    end

    // walk pointer and run start
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_begin) begin
            r_ptr <= r_pos[ADDR_BITS-1:0];
        end else if (i_cmd.step) begin
            r_ptr <= r_ptr + 1'b1;
        end
        if (i_cmd.first_set) begin
            r_first <= r_ptr;
        end
    end

    // output register: load on a result, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_kind      <= KIND_REPORT;
            r_stuck_on  <= '0;
            r_stuck_off <= '0;
            r_run_first <= '0;
            r_run_last  <= '0;
            r_total     <= '0;
            if (i_cmd.report) begin
                r_stuck_on  <= FIELD_BITS'(r_ref & still);
                r_stuck_off <= FIELD_BITS'(~r_ref & still);
            end else if (i_cmd.emit_done) begin
                r_kind  <= KIND_DONE;
                r_total <= TOTAL_BITS'(r_missing);
            end else begin
                r_kind      <= KIND_RUN;
                r_run_first <= FIELD_BITS'(run_first_val);
                r_run_last  <= FIELD_BITS'(run_last_val);
            end
        end
    end

    assign o_status.clear_last = &r_clr_cnt;
    assign o_status.pos_end    = r_pos[ADDR_BITS];
    assign o_status.ptr_top    = &r_ptr;
    assign o_status.seen       = ram_rdata;
    assign o_status.out_busy   = r_out_valid & ~i_out_ready;

    assign o_out_valid     = r_out_valid;
    assign o_kind          = r_kind;
    assign o_stuck_on      = r_stuck_on;
    assign o_stuck_off     = r_stuck_off;
    assign o_run_first     = r_run_first;
    assign o_run_last      = r_run_last;
    assign o_missing_total = r_total;

endmodule

// ----- design/adcmon_checker.sv -----
// ---------------------------------------------------------------------------
// ADC monitor checker
// Port-level checks on result contents, output hold and the clearing pass.
// ---------------------------------------------------------------------------
module adcmon_checker import adcmon_pkg::*; #(
    parameter int SAMPLE_BITS = 16
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_ready,
    input logic                  i_out_valid,
    input logic                  i_out_ready,
    input logic [KIND_BITS-1:0]  i_kind,
    input logic [FIELD_BITS-1:0] i_stuck_on,
    input logic [FIELD_BITS-1:0] i_stuck_off,
    input logic [FIELD_BITS-1:0] i_run_first,
    input logic [FIELD_BITS-1:0] i_run_last,
    input logic [TOTAL_BITS-1:0] i_missing_total
);

    localparam logic [TOTAL_BITS-1:0] MAX_TOTAL = TOTAL_BITS'(1) << SAMPLE_BITS;

    // no command taken in the cycle after reset: clearing pass runs
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_in_ready)
        else $error("command taken during clearing pass");

    // a report never overlaps stuck-on and stuck-off bits, other fields zero
    a_report_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_kind == KIND_REPORT) |->
            ((i_stuck_on & i_stuck_off) == '0 && i_run_first == '0
             && i_run_last == '0 && i_missing_total == '0))
        else $error("bad stuck-bit report");

    // a run is ordered and lies within the code range
    a_run_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_kind == KIND_RUN) |->
            (i_run_first <= i_run_last && TOTAL_BITS'(i_run_last) < MAX_TOTAL
             && i_stuck_on == '0 && i_stuck_off == '0 && i_missing_total == '0))
        else $error("bad missing run");

    // total never exceeds the number of codes
    a_done_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_kind == KIND_DONE) |->
            (i_missing_total <= MAX_TOTAL && i_run_first == '0 && i_run_last == '0))
        else $error("bad scan total");

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result dropped while stalled");

endmodule

bind adc_stuck_bit_and_missing_code_monitor_unit adcmon_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_kind          (o_out.kind),
    .i_stuck_on      (o_out.stuck_on),
    .i_stuck_off     (o_out.stuck_off),
    .i_run_first     (o_out.run_first),
    .i_run_last      (o_out.run_last),
    .i_missing_total (o_out.missing_total)
);

// ----- bench/adc_stuck_bit_and_missing_code_monitor_unit_tb.sv -----
// ---------------------------------------------------------------------------
// ADC stuck-bit and missing-code monitor testbench
// Drives sample, report and scan transactions into the monitor and
// predicts every report, missing run and scan total from a bench-side copy
// of the reference code, change mask and seen map. Directed tests cover the
// corner cases. Random phases follow, with sender gaps, receiver stalls, a
// long output hold-off and a full map walk per phase.
// ---------------------------------------------------------------------------
module adc_stuck_bit_and_missing_code_monitor_unit_tb;
    import adcmon_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 12;
    localparam int RESET_CYCLES = 9;
    localparam int SAMPLE_BITS  = 16;
    localparam int CODE_COUNT   = 1 << SAMPLE_BITS;
    localparam logic [FIELD_BITS-1:0] CODE_MASK = FIELD_BITS'(CODE_COUNT - 1);
    localparam logic [CMD_BITS-1:0] CMD_UNUSED = 2'd3;
    localparam logic [FIELD_BITS-1:0] REF_CODE = 16'hFFFF;

    // scans longer than this are mostly replaced to keep the run short
    localparam int SHORT_WALK   = 2048;
    localparam int HOLD_CYCLES  = 400;
    localparam int TAIL_CYCLES  = 16;
    // a full map walk plus the hold-off, taken several times over
    localparam int QUIET_LIMIT  = 280_000;

    typedef struct {
        logic [KIND_BITS-1:0]  kind;
        logic [FIELD_BITS-1:0] stuck_on;
        logic [FIELD_BITS-1:0] stuck_off;
        logic [FIELD_BITS-1:0] run_first;
        logic [FIELD_BITS-1:0] run_last;
        logic [TOTAL_BITS-1:0] missing_total;
    } t_monitor_result;

    bit   i_clk = 1'b0;
    logic i_rst_n;

    adcmon_in_if  cmd_ch ();
    adcmon_out_if res_ch ();

    adc_stuck_bit_and_missing_code_monitor_unit #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (cmd_ch),
        .o_out  (res_ch)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // predicted monitor state
    bit                    code_seen [CODE_COUNT];
    logic [FIELD_BITS-1:0] ref_code      = '0;
    bit                    ref_taken     = 1'b0;
    logic [FIELD_BITS-1:0] changed_mask  = '0;
    int unsigned           walk_pos      = 0;
    logic [TOTAL_BITS-1:0] walk_missing  = '0;
    logic [KIND_BITS-1:0]  last_scan_kind = KIND_RUN;

    t_monitor_result expected_results [$];
    int error_count = 0;

    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;
    int long_walks_left = 0;
    logic hold_results  = 1'b0;
    logic recv_ready    = 1'b0;
    int quiet_cycles    = 0;

    assign res_ch.ready = recv_ready;

    // Advance the predicted state by one accepted transaction
    function automatic void predict_transaction(input logic [CMD_BITS-1:0] cmd,
                                                input logic [FIELD_BITS-1:0] sample);
        t_monitor_result res;
        logic [FIELD_BITS-1:0] code;
        logic [FIELD_BITS-1:0] still;
        int unsigned p;
        int unsigned first;
        res = '{default: '0};
        case (cmd)
            CMD_SAMPLE: begin
                code = sample & CODE_MASK;
                if (!ref_taken) begin
                    ref_code  = code;
                    ref_taken = 1'b1;
                end
                changed_mask    = (changed_mask | (ref_code ^ code)) & CODE_MASK;
                code_seen[code] = 1'b1;
                walk_pos        = 0;
                walk_missing    = '0;
            end
            CMD_REPORT: begin
                still         = ~changed_mask & CODE_MASK;
                res.kind      = KIND_REPORT;
                res.stuck_on  = ref_code & still;
                res.stuck_off = ~ref_code & still;
                expected_results.push_back(res);
            end
            CMD_SCAN: begin
                p = walk_pos;
                while (p < CODE_COUNT && code_seen[p])
                    p++;
                if (p >= CODE_COUNT) begin
                    res.kind          = KIND_DONE;
                    res.missing_total = walk_missing;
                    walk_pos          = 0;
                    walk_missing      = '0;
                end else begin
                    first = p;
                    while (p < CODE_COUNT && !code_seen[p])
                        p++;
                    walk_missing  = walk_missing + TOTAL_BITS'(p - first);
                    walk_pos      = p;
                    res.kind      = KIND_RUN;
                    res.run_first = FIELD_BITS'(first);
                    res.run_last  = FIELD_BITS'(p - 1);
                end
                last_scan_kind = res.kind;
                expected_results.push_back(res);
            end
            default: ;
        endcase
    endfunction

    // Count codes the next scan would walk, giving up past the cap
    function automatic int unsigned scan_span(input int unsigned cap);
        int unsigned p;
        p = walk_pos;
        while (p < CODE_COUNT && code_seen[p] && p - walk_pos <= cap)
            p++;
        while (p < CODE_COUNT && !code_seen[p] && p - walk_pos <= cap)
            p++;
        return p - walk_pos;
    endfunction

    function automatic logic [FIELD_BITS-1:0] make_sample(input bit near_reference,
                                                          input int idx);
        int open_bits;
        int pick;
        // open reference bits one by one so stuck bits stay visible a while
        if (near_reference) begin
            open_bits = (idx / 20 > FIELD_BITS) ? FIELD_BITS : idx / 20;
            return REF_CODE ^ (FIELD_BITS'($urandom) & FIELD_BITS'((32'd1 << open_bits) - 1));
        end
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return FIELD_BITS'($urandom_range(0, 1023));
        else if (pick < 85)
            return FIELD_BITS'($urandom);
        else
            return REF_CODE ^ FIELD_BITS'($urandom_range(0, 255));
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            error_count++;
        end
    endfunction

    // Offer one transaction, idle before it at random, hold until accepted
    task automatic send_item(input logic [CMD_BITS-1:0] cmd,
                             input logic [FIELD_BITS-1:0] sample);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            cmd_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_ch.valid  <= 1'b1;
        cmd_ch.cmd    <= cmd;
        cmd_ch.sample <= sample;
        @(posedge i_clk);
        while (!cmd_ch.ready)
            @(posedge i_clk);
        predict_transaction(cmd, sample);
    endtask

    // Drop valid and wait for every predicted result
    task automatic drain();
        cmd_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic send_scan_gated();
        if (scan_span(SHORT_WALK + 1) <= SHORT_WALK) begin
            send_item(CMD_SCAN, FIELD_BITS'($urandom));
        end else if (long_walks_left > 0 && $urandom_range(0, 15) == 0) begin
            long_walks_left--;
            send_item(CMD_SCAN, FIELD_BITS'($urandom));
        end else begin
            send_item(CMD_REPORT, FIELD_BITS'($urandom));
        end
    endtask

    // Scan until the walk reports its total
    task automatic walk_to_end(inout int sent);
        do begin
            send_item(CMD_SCAN, FIELD_BITS'($urandom));
            sent++;
        end while (last_scan_kind != KIND_DONE);
    endtask

    task automatic test_report_before_sample();
        send_item(CMD_REPORT, 16'hFFFF);
        drain();
    endtask

    task automatic test_scan_empty_map();
        send_item(CMD_SCAN, 16'h0000);
        send_item(CMD_SCAN, 16'hFFFF);
        drain();
    endtask

    task automatic test_unused_command();
        send_item(CMD_UNUSED, 16'h0000);
        send_item(CMD_UNUSED, 16'hFFFF);
        send_item(CMD_REPORT, 16'h0000);
        drain();
    endtask

    task automatic test_reference_and_stuck_bits();
        send_item(CMD_SAMPLE, REF_CODE);
        send_item(CMD_REPORT, 16'h0000);
        send_item(CMD_SAMPLE, 16'h7FFE);
        send_item(CMD_REPORT, 16'h0000);
        drain();
    endtask

    // Two runs, the total, then a fresh walk from code zero
    task automatic test_missing_runs();
        repeat (4)
            send_item(CMD_SCAN, 16'h0000);
        drain();
    endtask

    task automatic test_sample_restarts_walk();
        send_item(CMD_SAMPLE, 16'h7FFE);
        send_item(CMD_SCAN, 16'h0000);
        drain();
    endtask

    // Hold the receiver off while commands keep coming
    task automatic test_output_backpressure();
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        fork
            begin
                hold_results <= 1'b1;
                repeat (HOLD_CYCLES)
                    @(posedge i_clk);
                hold_results <= 1'b0;
            end
        join_none
        for (int i = 0; i < 24; i++) begin
            if (i % 3 == 2)
                send_item(CMD_SAMPLE, make_sample(1'b0, i));
            else
                send_item(CMD_REPORT, FIELD_BITS'($urandom));
        end
        drain();
    endtask

    task automatic test_random_traffic(input int n_items, input int idle_pct,
                                       input int stall_pct, input bit near_reference);
        int sent;
        int pick;
        int burst;
        int walk_at;
        bit walked;
        sender_idle_pct = idle_pct;
        recv_stall_pct  = stall_pct;
        long_walks_left = 1;
        walk_at = $urandom_range(n_items / 4, 3 * n_items / 4);
        walked  = 1'b0;
        sent    = 0;
        while (sent < n_items) begin
            pick = $urandom_range(0, 99);
            if (!walked && sent >= walk_at) begin
                walked = 1'b1;
                walk_to_end(sent);
            end else if (pick < 45) begin
                send_item(CMD_SAMPLE, make_sample(near_reference, sent));
                sent++;
            end else if (pick < 60) begin
                send_item(CMD_REPORT, FIELD_BITS'($urandom));
                sent++;
            end else if (pick < 95) begin
                burst = $urandom_range(1, 6);
                repeat (burst) begin
                    send_scan_gated();
                    sent++;
                end
            end else begin
                send_item(CMD_UNUSED, FIELD_BITS'($urandom));
            end
        end
        drain();
    endtask

    // Drive the receiver ready with random stalls and the hold-off
    always @(posedge i_clk) begin
        recv_ready <= !hold_results && ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Compare each result transaction with the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_monitor_result want;
        if (i_rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result transaction, kind 0x%0h", res_ch.kind);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                check_field("kind", 32'(want.kind), 32'(res_ch.kind));
                check_field("stuck_on", 32'(want.stuck_on), 32'(res_ch.stuck_on));
                check_field("stuck_off", 32'(want.stuck_off), 32'(res_ch.stuck_off));
                check_field("run_first", 32'(want.run_first), 32'(res_ch.run_first));
                check_field("run_last", 32'(want.run_last), 32'(res_ch.run_last));
                check_field("missing_total", 32'(want.missing_total),
                            32'(res_ch.missing_total));
            end
        end
    end

    // End the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((cmd_ch.valid === 1'b1 && cmd_ch.ready === 1'b1) ||
            (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n       <= 1'b0;
        cmd_ch.valid  <= 1'b0;
        cmd_ch.cmd    <= CMD_SAMPLE;
        cmd_ch.sample <= '0;
        repeat (RESET_CYCLES)
            @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_report_before_sample();
        test_scan_empty_map();
        test_unused_command();
        test_reference_and_stuck_bits();
        test_missing_runs();
        test_sample_restarts_walk();

        test_random_traffic(325, 0, 0, 1'b1);
        test_output_backpressure();
        test_random_traffic(325, 68, 0, 1'b0);
        test_random_traffic(325, 0, 68, 1'b0);
        test_random_traffic(325, 20, 20, 1'b0);

        drain();
        repeat (TAIL_CYCLES)
            @(posedge i_clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
